### rtl/core/agbl_pkg.sv
`timescale 1ns / 1ps
package agbl_pkg;

  // defaults for the top level parameters
  localparam int MAX_VERTICAL_STEPS_DEF   = 63;
  localparam int MAX_HORIZONTAL_STEPS_DEF = 63;
  localparam int GAIN_WIDTH_DEF           = 24;

  // fixed field widths
  localparam int STEPS_W = 6;
  localparam int INDEX_W = 6;
  localparam int ANGLE_W = 17;

  // angle * steps, then / 360 done as (>> 3) and multiply by reciprocal of 45
  localparam int PROD_W      = ANGLE_W + STEPS_W;
  localparam int PRE_SHIFT   = 3;
  localparam int QUOT_IN_W   = PROD_W - PRE_SHIFT;
  localparam int RECIP_W     = 21;
  localparam int RECIP_SHIFT = 26;
  localparam int RECIP_PROD_W = QUOT_IN_W + RECIP_W;
  // ceil(2^26 / 45); exact floor for every dividend below 2^20
  localparam logic [RECIP_W-1:0] RECIP_45 = 21'd1491309;

  // grid coordinate: 7 integer bits, 8 fractional bits
  localparam int FRAC_W   = 8;
  localparam int COORD_W  = 15;
  localparam int CELL_W   = COORD_W - FRAC_W;
  localparam int WEIGHT_W = FRAC_W + 1;
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 9'd256;

  // blend is in units of 2^-16; bias for round half up
  localparam int BLEND_SHIFT = 2 * FRAC_W;
  localparam int ROUND_BIAS  = 32768;

  // commands
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  // APB register map, word addressed
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = APB_ADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_VERTICAL   = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_HORIZONTAL = 1'b1;
  localparam logic [STEPS_W-1:0]   STEPS_RESET    = 6'd1;

  // result queue
  localparam int OQ_DEPTH = 4;
  localparam int OQ_PTR_W = 2;
  localparam int OQ_CNT_W = 3;

  typedef struct packed {
    logic                cmd;
    logic                oor;
    logic [INDEX_W-1:0]  row;
    logic [INDEX_W-1:0]  col;
    logic [CELL_W-1:0]   i;
    logic [CELL_W-1:0]   i1;
    logic [CELL_W-1:0]   j;
    logic [CELL_W-1:0]   j1;
    logic [WEIGHT_W-1:0] wi0;
    logic [WEIGHT_W-1:0] wi1;
    logic [WEIGHT_W-1:0] wj0;
    logic [WEIGHT_W-1:0] wj1;
  } agbl_item_t;

  typedef struct packed {
    logic valid;
    logic oor;
  } agbl_push_t;

  typedef struct packed {
    logic [OQ_CNT_W-1:0] count;
    logic [OQ_CNT_W-1:0] reserved;
    logic                space;
  } agbl_oq_stat_t;

endpackage

### rtl/core/agbl_chan_if.sv
`timescale 1ns / 1ps
interface agbl_in_if #(
  parameter int GAIN_WIDTH = agbl_pkg::GAIN_WIDTH_DEF
);
  logic                              valid;
  logic                              ready;
  logic                              command;
  logic [agbl_pkg::INDEX_W-1:0]      row_index;
  logic [agbl_pkg::INDEX_W-1:0]      column_index;
  logic signed [GAIN_WIDTH-1:0]      entry_value;
  logic [agbl_pkg::ANGLE_W-1:0]      theta_angle;
  logic [agbl_pkg::ANGLE_W-1:0]      phi_angle;

  modport source (
    output valid, command, row_index, column_index, entry_value, theta_angle, phi_angle,
    input  ready
  );
  modport sink (
    input  valid, command, row_index, column_index, entry_value, theta_angle, phi_angle,
    output ready
  );
endinterface

interface agbl_out_if #(
  parameter int GAIN_WIDTH = agbl_pkg::GAIN_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [GAIN_WIDTH-1:0] gain_value;
  logic                         out_of_range;

  modport source (
    output valid, gain_value, out_of_range,
    input  ready
  );
  modport sink (
    input  valid, gain_value, out_of_range,
    output ready
  );
endinterface

### rtl/core/agbl_scale.sv
`timescale 1ns / 1ps
module agbl_scale #(
  parameter int MAX_VERTICAL_STEPS   = agbl_pkg::MAX_VERTICAL_STEPS_DEF,
  parameter int MAX_HORIZONTAL_STEPS = agbl_pkg::MAX_HORIZONTAL_STEPS_DEF,
  parameter int GAIN_WIDTH           = agbl_pkg::GAIN_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  agbl_in_if.sink                         in_ch,
  input  logic [agbl_pkg::STEPS_W-1:0]    vertical_steps,
  input  logic [agbl_pkg::STEPS_W-1:0]    horizontal_steps,
  output logic                            out_valid,
  input  logic                            out_ready,
  output agbl_pkg::agbl_item_t            out_item,
  output logic signed [GAIN_WIDTH-1:0]    out_value
);

  // stage 1: angle * steps
  logic                           s1_valid;
  logic                           s1_cmd;
  logic [agbl_pkg::INDEX_W-1:0]   s1_row;
  logic [agbl_pkg::INDEX_W-1:0]   s1_col;
  logic signed [GAIN_WIDTH-1:0]   s1_value;
  logic [agbl_pkg::PROD_W-1:0]    s1_tprod;
  logic [agbl_pkg::PROD_W-1:0]    s1_pprod;

  // stage 2: divide by 360
  logic                           s2_valid;
  logic                           s2_cmd;
  logic [agbl_pkg::INDEX_W-1:0]   s2_row;
  logic [agbl_pkg::INDEX_W-1:0]   s2_col;
  logic signed [GAIN_WIDTH-1:0]   s2_value;
  logic [agbl_pkg::COORD_W-1:0]   s2_ts;
  logic [agbl_pkg::COORD_W-1:0]   s2_ps;

  logic [agbl_pkg::RECIP_PROD_W-1:0] tq;
  logic [agbl_pkg::RECIP_PROD_W-1:0] pq;

  // stage 3: cell, weights, range check
  logic                           s1_ready;
  logic                           s2_ready;
  logic                           s3_ready;
  logic [agbl_pkg::FRAC_W-1:0]    fi;
  logic [agbl_pkg::FRAC_W-1:0]    fj;
  agbl_pkg::agbl_item_t           s3_next;

  assign s3_ready    = !out_valid || out_ready;
  assign s2_ready    = !s2_valid || s3_ready;
  assign s1_ready    = !s1_valid || s2_ready;
  assign in_ch.ready = s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid <= in_ch.valid;
      end
      if (s2_ready) begin
        s2_valid <= s1_valid;
      end
      if (s3_ready) begin
        out_valid <= s2_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1_cmd   <= in_ch.command;
      s1_row   <= in_ch.row_index;
      s1_col   <= in_ch.column_index;
      s1_value <= in_ch.entry_value;
      s1_tprod <= agbl_pkg::PROD_W'(in_ch.theta_angle) * agbl_pkg::PROD_W'(vertical_steps);
      s1_pprod <= agbl_pkg::PROD_W'(in_ch.phi_angle) * agbl_pkg::PROD_W'(horizontal_steps);
    end
  end

  assign tq = agbl_pkg::RECIP_PROD_W'(s1_tprod[agbl_pkg::PROD_W-1:agbl_pkg::PRE_SHIFT]) *
              agbl_pkg::RECIP_PROD_W'(agbl_pkg::RECIP_45);
  assign pq = agbl_pkg::RECIP_PROD_W'(s1_pprod[agbl_pkg::PROD_W-1:agbl_pkg::PRE_SHIFT]) *
              agbl_pkg::RECIP_PROD_W'(agbl_pkg::RECIP_45);

  always_ff @(posedge clk) begin
    if (s2_ready) begin
      s2_cmd   <= s1_cmd;
      s2_row   <= s1_row;
      s2_col   <= s1_col;
      s2_value <= s1_value;
      s2_ts    <= tq[agbl_pkg::RECIP_SHIFT +: agbl_pkg::COORD_W];
      s2_ps    <= pq[agbl_pkg::RECIP_SHIFT +: agbl_pkg::COORD_W];
    end
  end

  assign fi = s2_ts[agbl_pkg::FRAC_W-1:0];
  assign fj = s2_ps[agbl_pkg::FRAC_W-1:0];

  always_comb begin
    s3_next     = '0;
    s3_next.cmd = s2_cmd;
    s3_next.row = s2_row;
    s3_next.col = s2_col;
    s3_next.i   = s2_ts[agbl_pkg::COORD_W-1:agbl_pkg::FRAC_W];
    s3_next.j   = s2_ps[agbl_pkg::COORD_W-1:agbl_pkg::FRAC_W];
    // on a grid line the far neighbor collapses onto the near one
    s3_next.i1  = s3_next.i + agbl_pkg::CELL_W'(fi != '0);
    s3_next.j1  = s3_next.j + agbl_pkg::CELL_W'(fj != '0);
    s3_next.oor = (32'(s3_next.i1) > 32'(vertical_steps)) ||
                  (32'(s3_next.i1) > MAX_VERTICAL_STEPS) ||
                  (32'(s3_next.j1) > 32'(horizontal_steps)) ||
                  (32'(s3_next.j1) > MAX_HORIZONTAL_STEPS);
    s3_next.wi1 = agbl_pkg::WEIGHT_W'(fi);
    s3_next.wi0 = agbl_pkg::WEIGHT_ONE - agbl_pkg::WEIGHT_W'(fi);
    s3_next.wj1 = agbl_pkg::WEIGHT_W'(fj);
    s3_next.wj0 = agbl_pkg::WEIGHT_ONE - agbl_pkg::WEIGHT_W'(fj);
  end

  always_ff @(posedge clk) begin
    if (s3_ready) begin
      out_item  <= s3_next;
      out_value <= s2_value;
    end
  end

endmodule

### rtl/core/agbl_engine.sv
`timescale 1ns / 1ps
module agbl_engine #(
  parameter int MAX_VERTICAL_STEPS   = agbl_pkg::MAX_VERTICAL_STEPS_DEF,
  parameter int MAX_HORIZONTAL_STEPS = agbl_pkg::MAX_HORIZONTAL_STEPS_DEF,
  parameter int GAIN_WIDTH           = agbl_pkg::GAIN_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  agbl_pkg::agbl_item_t         in_item,
  input  logic signed [GAIN_WIDTH-1:0] in_value,
  input  logic                         space,
  output logic                         reserve,
  output agbl_pkg::agbl_push_t         push,
  output logic signed [GAIN_WIDTH-1:0] push_gain
);

  localparam int RB     = $clog2(MAX_VERTICAL_STEPS + 1);
  localparam int CB     = $clog2(MAX_HORIZONTAL_STEPS + 1);
  localparam int AW     = RB + CB;
  localparam int DEPTH  = 1 << AW;
  localparam int PW     = GAIN_WIDTH + agbl_pkg::WEIGHT_W;
  localparam int ACCW   = GAIN_WIDTH + 2 * agbl_pkg::WEIGHT_W - 1;

  logic signed [GAIN_WIDTH-1:0] grid [DEPTH];

  // item being worked on
  logic                         cur_valid;
  agbl_pkg::agbl_item_t         cur_item;
  logic signed [GAIN_WIDTH-1:0] cur_value;
  logic [1:0]                   phase;
  logic                         cur_write;
  logic                         cur_done;
  logic                         load;

  logic                         mem_we;
  logic [AW-1:0]                mem_addr;
  logic signed [GAIN_WIDTH-1:0] mem_rdata;
  logic [agbl_pkg::CELL_W-1:0]  rsel_i;
  logic [agbl_pkg::CELL_W-1:0]  rsel_j;
  logic                         wr_in_grid;

  // per-term tags following the read through the multiply pipe
  logic                              t1_valid, t1_first, t1_last, t1_oor;
  logic [agbl_pkg::WEIGHT_W-1:0]     t1_wi, t1_wj;
  logic                              t2_valid, t2_first, t2_last, t2_oor;
  logic [agbl_pkg::WEIGHT_W-1:0]     t2_wi;
  logic                              t3_valid, t3_first, t3_last, t3_oor;
  logic signed [PW-1:0]              p;
  logic signed [ACCW-1:0]            q;
  logic signed [ACCW-1:0]            acc;
  logic signed [ACCW-1:0]            acc_next;

  assign cur_write = cur_item.cmd == agbl_pkg::CMD_WRITE;
  assign cur_done  = cur_valid && (cur_write || cur_item.oor || phase == 2'd3);
  // a lookup enters only with a result slot reserved downstream
  assign in_ready  = (!cur_valid || cur_done) &&
                     (in_item.cmd == agbl_pkg::CMD_WRITE || space);
  assign load      = in_valid && in_ready;
  assign reserve   = load && in_item.cmd == agbl_pkg::CMD_LOOKUP;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      phase     <= '0;
    end else begin
      if (load) begin
        cur_valid <= 1'b1;
        phase     <= '0;
      end else if (cur_done) begin
        cur_valid <= 1'b0;
      end else if (cur_valid) begin
        phase <= phase + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur_item  <= in_item;
      cur_value <= in_value;
    end
  end

  // phase bit 0 picks the row neighbor, bit 1 the column neighbor
  assign rsel_i     = phase[0] ? cur_item.i1 : cur_item.i;
  assign rsel_j     = phase[1] ? cur_item.j1 : cur_item.j;
  assign wr_in_grid = (32'(cur_item.row) <= MAX_VERTICAL_STEPS) &&
                      (32'(cur_item.col) <= MAX_HORIZONTAL_STEPS);
  assign mem_we     = cur_valid && cur_write && wr_in_grid;
  assign mem_addr   = cur_write ? {RB'(cur_item.row), CB'(cur_item.col)}
                                : {RB'(rsel_i), CB'(rsel_j)};

  // single port: one write or one read per cycle, so order is kept
  always_ff @(posedge clk) begin
    if (mem_we) begin
      grid[mem_addr] <= cur_value;
    end
    mem_rdata <= grid[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t1_valid <= 1'b0;
      t2_valid <= 1'b0;
      t3_valid <= 1'b0;
    end else begin
      t1_valid <= cur_valid && !cur_write;
      t2_valid <= t1_valid;
      t3_valid <= t2_valid;
    end
  end

  always_ff @(posedge clk) begin
    t1_first <= phase == 2'd0;
    t1_last  <= cur_done;
    t1_oor   <= cur_item.oor;
    t1_wi    <= phase[0] ? cur_item.wi1 : cur_item.wi0;
    t1_wj    <= phase[1] ? cur_item.wj1 : cur_item.wj0;

    t2_first <= t1_first;
    t2_last  <= t1_last;
    t2_oor   <= t1_oor;
    t2_wi    <= t1_wi;
    p        <= PW'(mem_rdata) * PW'($signed({1'b0, t1_wj}));

    t3_first <= t2_first;
    t3_last  <= t2_last;
    t3_oor   <= t2_oor;
    q        <= ACCW'(p) * ACCW'($signed({1'b0, t2_wi}));
  end

  // rounding bias is folded into the first term
  assign acc_next = (t3_first ? ACCW'(agbl_pkg::ROUND_BIAS) : acc) + q;

  always_ff @(posedge clk) begin
    if (t3_valid) begin
      acc <= acc_next;
    end
  end

  assign push.valid = t3_valid && t3_last;
  assign push.oor   = t3_oor;
  assign push_gain  = t3_oor ? '0 : acc_next[agbl_pkg::BLEND_SHIFT +: GAIN_WIDTH];

endmodule

### rtl/core/agbl_outq.sv
`timescale 1ns / 1ps
module agbl_outq #(
  parameter int GAIN_WIDTH = agbl_pkg::GAIN_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  agbl_pkg::agbl_push_t         push,
  input  logic signed [GAIN_WIDTH-1:0] push_gain,
  input  logic                         reserve,
  output agbl_pkg::agbl_oq_stat_t      stat,
  agbl_out_if.source                   out_ch
);

  logic signed [GAIN_WIDTH-1:0]   gain_q [agbl_pkg::OQ_DEPTH];
  logic                           oor_q  [agbl_pkg::OQ_DEPTH];
  logic [agbl_pkg::OQ_PTR_W-1:0]  wr_ptr;
  logic [agbl_pkg::OQ_PTR_W-1:0]  rd_ptr;
  logic [agbl_pkg::OQ_CNT_W-1:0]  count;
  logic [agbl_pkg::OQ_CNT_W-1:0]  reserved;
  logic                           pop;

  assign pop                = out_ch.valid && out_ch.ready;
  assign out_ch.valid       = count != '0;
  assign out_ch.gain_value  = gain_q[rd_ptr];
  assign out_ch.out_of_range = oor_q[rd_ptr];

  assign stat.count    = count;
  assign stat.reserved = reserved;
  // a slot is held from the lookup's entry until its result leaves
  assign stat.space    = reserved < agbl_pkg::OQ_CNT_W'(agbl_pkg::OQ_DEPTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      count    <= '0;
      reserved <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count    <= count + agbl_pkg::OQ_CNT_W'(push.valid) - agbl_pkg::OQ_CNT_W'(pop);
      reserved <= reserved + agbl_pkg::OQ_CNT_W'(reserve) - agbl_pkg::OQ_CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      gain_q[wr_ptr] <= push_gain;
      oor_q[wr_ptr]  <= push.oor;
    end
  end

endmodule

### rtl/core/antenna_gain_bilinear_lookup_unit.sv
`timescale 1ns / 1ps
// Antenna gain lookup over a stored grid with bilinear interpolation. Write
// transactions (command 0) store one grid gain; lookup transactions (command
// 1) scale elevation and azimuth by steps/360 into 8-bit fractional grid
// coordinates and return the blend of the four neighboring gains, rounded
// half up to the units of the stored gains, or zero with out_of_range set
// when the cell leaves the grid. All grid traffic uses one single-port
// memory, one access per cycle: a write or an out-of-range lookup takes
// one access, an in-range lookup four reads. Sustained rate is one write
// per cycle; a lookup holds the memory until its last read. A lookup is
// scaled, then read, then multiplied and accumulated before its result
// is queued. Transactions complete in order; a lookup sees every earlier
// write. A four-entry result queue lets lookups keep flowing while results
// wait. Grid entries read before being written return undefined data.
// Steps registers sit at APB byte addresses 0 (vertical) and 4
// (horizontal), reset value 1; write them only while idle.
module antenna_gain_bilinear_lookup_unit #(
  parameter int MAX_VERTICAL_STEPS   = agbl_pkg::MAX_VERTICAL_STEPS_DEF,
  parameter int MAX_HORIZONTAL_STEPS = agbl_pkg::MAX_HORIZONTAL_STEPS_DEF,
  parameter int GAIN_WIDTH           = agbl_pkg::GAIN_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [agbl_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [agbl_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [agbl_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready,
  agbl_in_if.sink                           lookup_in,
  agbl_out_if.source                        gain_out
);

  logic [agbl_pkg::STEPS_W-1:0]   vertical_steps;
  logic [agbl_pkg::STEPS_W-1:0]   horizontal_steps;
  logic [agbl_pkg::REG_IDX_W-1:0] reg_idx;
  logic                           cfg_we;

  logic                           sc_valid;
  logic                           sc_ready;
  agbl_pkg::agbl_item_t           sc_item;
  logic signed [GAIN_WIDTH-1:0]   sc_value;
  logic                           eng_reserve;
  agbl_pkg::agbl_push_t           eng_push;
  logic signed [GAIN_WIDTH-1:0]   eng_gain;
  agbl_pkg::agbl_oq_stat_t        oq_stat;

  assign pready  = 1'b1;
  assign reg_idx = paddr[agbl_pkg::APB_ADDR_W-1:2];
  assign cfg_we  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertical_steps   <= agbl_pkg::STEPS_RESET;
      horizontal_steps <= agbl_pkg::STEPS_RESET;
    end else if (cfg_we) begin
      case (reg_idx)
        agbl_pkg::REG_VERTICAL: begin
          vertical_steps <= pwdata[agbl_pkg::STEPS_W-1:0];
        end
        agbl_pkg::REG_HORIZONTAL: begin
          horizontal_steps <= pwdata[agbl_pkg::STEPS_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      agbl_pkg::REG_VERTICAL:   prdata = agbl_pkg::APB_DATA_W'(vertical_steps);
      agbl_pkg::REG_HORIZONTAL: prdata = agbl_pkg::APB_DATA_W'(horizontal_steps);
      default:                  prdata = '0;
    endcase
  end

  agbl_scale #(
    .MAX_VERTICAL_STEPS   (MAX_VERTICAL_STEPS),
    .MAX_HORIZONTAL_STEPS (MAX_HORIZONTAL_STEPS),
    .GAIN_WIDTH           (GAIN_WIDTH)
  ) u_scale (
    .clk              (clk),
    .rst              (rst),
    .in_ch            (lookup_in),
    .vertical_steps   (vertical_steps),
    .horizontal_steps (horizontal_steps),
    .out_valid        (sc_valid),
    .out_ready        (sc_ready),
    .out_item         (sc_item),
    .out_value        (sc_value)
  );

  agbl_engine #(
    .MAX_VERTICAL_STEPS   (MAX_VERTICAL_STEPS),
    .MAX_HORIZONTAL_STEPS (MAX_HORIZONTAL_STEPS),
    .GAIN_WIDTH           (GAIN_WIDTH)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sc_valid),
    .in_ready  (sc_ready),
    .in_item   (sc_item),
    .in_value  (sc_value),
    .space     (oq_stat.space),
    .reserve   (eng_reserve),
    .push      (eng_push),
    .push_gain (eng_gain)
  );

  agbl_outq #(
    .GAIN_WIDTH (GAIN_WIDTH)
  ) u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (eng_push),
    .push_gain (eng_gain),
    .reserve   (eng_reserve),
    .stat      (oq_stat),
    .out_ch    (gain_out)
  );

  a_queue_within_reservation: assert property (@(posedge clk) disable iff (rst)
    oq_stat.count <= oq_stat.reserved)
    else $error("result queue holds more entries than reserved slots");

  a_reserve_needs_space: assert property (@(posedge clk) disable iff (rst)
    eng_reserve |-> oq_stat.space)
    else $error("lookup entered engine without a free result slot");

  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    eng_push.valid |-> oq_stat.count < agbl_pkg::OQ_CNT_W'(agbl_pkg::OQ_DEPTH))
    else $error("result pushed into a full queue");

  a_oor_gives_zero: assert property (@(posedge clk) disable iff (rst)
    gain_out.valid && gain_out.out_of_range |-> gain_out.gain_value == '0)
    else $error("out of range result carries a nonzero gain");

endmodule
